FILE: rtl/core/assert_macros.svh
// assertion helpers shared by the rtl modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold on every clock edge out of reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// same-cycle implication
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: rtl/core/ms_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ms_pkg;

  localparam int DATA_W    = 32;
  localparam int DEPTH_DEF = 64;

  // controller to datapath
  typedef struct packed {
    logic wr_en;
    logic wr_bank;
    logic wr_in;     // write the input beat rather than a merge head
    logic wr_left;   // merge takes the left run head
    logic rd_bank;
    logic out_load;
    logic out_last;
    logic out_ovf;
  } ms_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic a_lt_b;
    logic out_free;
  } ms_sts_t;

endpackage

`default_nettype wire

FILE: rtl/core/merge_sorter_core.sv
// after the last input beat the sort runs ceil(log2 n)
// merge passes, each a setup step (S_SET) and a merge (S_RUN) per run pair, then results
// leave via S_EMIT_RD and S_EMIT_WR, waiting while the output register is full and not taken
// merge passes write one element per cycle; each result is read, then loaded for output
// reset: rst_n synchronous, active low; clears count, drop flag, fsm and out valid,
// memory contents are not cleared
`timescale 1ns / 1ps
`default_nettype none

module merge_sorter_core #(
  parameter int DEPTH = ms_pkg::DEPTH_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_tvalid,
  output logic                           in_tready,
  input  wire logic [ms_pkg::DATA_W-1:0] in_tdata,   // [31:0] value
  input  wire logic                      in_tlast,
  output logic                           out_tvalid,
  input  wire logic                      out_tready,
  output logic [ms_pkg::DATA_W-1:0]      out_tdata,  // [31:0] sorted_value
  output logic                           out_tlast,
  output logic                           out_tuser   // [0] overflow
);
  import ms_pkg::*;

  localparam int AW = $clog2(DEPTH);

  ms_cmd_t       cmd;
  ms_sts_t       sts;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr_a;
  logic [AW-1:0] rd_addr_b;

  ms_ctrl #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tlast  (in_tlast),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd),
    .wr_addr   (wr_addr),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b)
  );

  ms_dp #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .wr_addr    (wr_addr),
    .rd_addr_a  (rd_addr_a),
    .rd_addr_b  (rd_addr_b),
    .in_data    (in_tdata),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

`default_nettype wire

FILE: rtl/core/ms_dp.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module ms_dp #(
  parameter int DEPTH = ms_pkg::DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire ms_pkg::ms_cmd_t           cmd,
  input  wire logic [AW-1:0]             wr_addr,
  input  wire logic [AW-1:0]             rd_addr_a,
  input  wire logic [AW-1:0]             rd_addr_b,
  input  wire logic [ms_pkg::DATA_W-1:0] in_data,
  output ms_pkg::ms_sts_t                sts,
  output logic                           out_tvalid,
  input  wire logic                      out_tready,
  output logic [ms_pkg::DATA_W-1:0]      out_tdata,
  output logic                           out_tlast,
  output logic                           out_tuser
);
  import ms_pkg::*;

  logic [DATA_W-1:0] mem0 [DEPTH];
  logic [DATA_W-1:0] mem1 [DEPTH];

  logic [DATA_W-1:0] rd_a_r;
  logic [DATA_W-1:0] rd_b_r;
  logic [DATA_W-1:0] wdata;

  logic              out_valid_r;
  logic [DATA_W-1:0] out_data_r;
  logic              out_last_r;
  logic              out_ovf_r;

  assign wdata = cmd.wr_in ? in_data : (cmd.wr_left ? rd_a_r : rd_b_r);

  always_ff @(posedge clk) begin
    if (cmd.wr_en && !cmd.wr_bank) begin
      mem0[wr_addr] <= wdata;
    end
    if (cmd.wr_en && cmd.wr_bank) begin
      mem1[wr_addr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rd_a_r <= cmd.rd_bank ? mem1[rd_addr_a] : mem0[rd_addr_a];
    rd_b_r <= cmd.rd_bank ? mem1[rd_addr_b] : mem0[rd_addr_b];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r <= rd_a_r;
      out_last_r <= cmd.out_last;
      out_ovf_r  <= cmd.out_ovf;
    end
  end

  assign sts.a_lt_b   = $signed(rd_a_r) < $signed(rd_b_r);
  assign sts.out_free = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_ovf_r;

  // input beats always land in bank 0
  `ASSERT_IMPL(a_load_bank0, clk, rst_n, cmd.wr_en && cmd.wr_in, !cmd.wr_bank)
  `ASSERT_NEXT(a_load_shows, clk, rst_n, cmd.out_load, out_tvalid)

endmodule

`default_nettype wire

FILE: rtl/core/ms_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module ms_ctrl #(
  parameter int DEPTH = ms_pkg::DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_tvalid,
  input  wire logic            in_tlast,
  output logic                 in_tready,
  input  wire ms_pkg::ms_sts_t sts,
  output ms_pkg::ms_cmd_t      cmd,
  output logic [AW-1:0]        wr_addr,
  output logic [AW-1:0]        rd_addr_a,
  output logic [AW-1:0]        rd_addr_b
);
  import ms_pkg::*;

  // counters hold up to twice the depth (run width doubling)
  localparam int CW = $clog2(DEPTH + 1) + 1;

  typedef enum logic [4:0] {
    S_LOAD    = 5'b00001,
    S_SET     = 5'b00010,
    S_RUN     = 5'b00100,
    S_EMIT_RD = 5'b01000,
    S_EMIT_WR = 5'b10000
  } state_t;

  state_t        state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] n_r, n_nxt;
  logic [CW-1:0] w_r, w_nxt;
  logic [CW-1:0] lo_r, lo_nxt;
  logic [CW-1:0] mid_r, mid_nxt;
  logic [CW-1:0] hi_r, hi_nxt;
  logic [CW-1:0] i_r, i_nxt;
  logic [CW-1:0] j_r, j_nxt;
  logic [CW-1:0] k_r, k_nxt;
  logic          bank_r, bank_nxt;
  logic          drop_r, drop_nxt;

  logic          accept;
  logic          has_room;
  logic [CW:0]   lo_w;
  logic [CW:0]   lo_2w;
  logic [CW-1:0] mid_c;
  logic [CW-1:0] hi_c;
  logic [CW-1:0] k_inc;
  logic [CW-1:0] w_dbl;
  logic          take_left;

  assign accept   = in_tvalid && in_tready;
  assign has_room = cnt_r < CW'(DEPTH);
  assign lo_w     = {1'b0, lo_r} + {1'b0, w_r};
  assign lo_2w    = {1'b0, lo_r} + {w_r, 1'b0};
  assign mid_c    = (lo_w > {1'b0, n_r}) ? n_r : lo_w[CW-1:0];
  assign hi_c     = (lo_2w > {1'b0, n_r}) ? n_r : lo_2w[CW-1:0];
  assign k_inc    = k_r + CW'(1);
  assign w_dbl    = {w_r[CW-2:0], 1'b0};
  // ties go to the right run
  assign take_left = (i_r < mid_r) && ((j_r >= hi_r) || sts.a_lt_b);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    n_nxt     = n_r;
    w_nxt     = w_r;
    lo_nxt    = lo_r;
    mid_nxt   = mid_r;
    hi_nxt    = hi_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    k_nxt     = k_r;
    bank_nxt  = bank_r;
    drop_nxt  = drop_r;
    in_tready = 1'b0;
    cmd       = '0;
    cmd.rd_bank = bank_r;
    wr_addr   = k_r[AW-1:0];

    case (state_r)
      S_LOAD: begin
        in_tready = 1'b1;
        cmd.wr_in = 1'b1;
        wr_addr   = cnt_r[AW-1:0];
        if (accept) begin
          cmd.wr_en = has_room;
          if (has_room) begin
            cnt_nxt = cnt_r + CW'(1);
          end else begin
            drop_nxt = 1'b1;
          end
          if (in_tlast) begin
            n_nxt    = has_room ? cnt_r + CW'(1) : cnt_r;
            w_nxt    = CW'(1);
            lo_nxt   = '0;
            k_nxt    = '0;
            bank_nxt = 1'b0;
            // a set of one is already sorted
            state_nxt = (has_room && cnt_r == '0) ? S_EMIT_RD : S_SET;
          end
        end
      end

      S_SET: begin
        mid_nxt   = mid_c;
        hi_nxt    = hi_c;
        i_nxt     = lo_r;
        j_nxt     = mid_c;
        k_nxt     = lo_r;
        state_nxt = S_RUN;
      end

      S_RUN: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_bank = !bank_r;
        cmd.wr_left = take_left;
        k_nxt       = k_inc;
        if (take_left) begin
          i_nxt = i_r + CW'(1);
        end else begin
          j_nxt = j_r + CW'(1);
        end
        if (k_inc == hi_r) begin
          if (hi_r == n_r) begin
            // pass done, result now in the other bank
            bank_nxt = !bank_r;
            w_nxt    = w_dbl;
            lo_nxt   = '0;
            if (w_dbl >= n_r) begin
              k_nxt     = '0;
              state_nxt = S_EMIT_RD;
            end else begin
              state_nxt = S_SET;
            end
          end else begin
            lo_nxt    = hi_r;
            state_nxt = S_SET;
          end
        end
      end

      S_EMIT_RD: begin
        if (sts.out_free) begin
          state_nxt = S_EMIT_WR;
        end
      end

      S_EMIT_WR: begin
        cmd.out_load = 1'b1;
        cmd.out_last = (k_inc == n_r);
        cmd.out_ovf  = drop_r;
        k_nxt        = k_inc;
        if (k_inc == n_r) begin
          cnt_nxt   = '0;
          drop_nxt  = 1'b0;
          bank_nxt  = 1'b0;
          state_nxt = S_LOAD;
        end else begin
          state_nxt = S_EMIT_RD;
        end
      end

      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  // read data is registered, so address with the next pointers
  assign rd_addr_a = (state_r == S_EMIT_RD) ? k_r[AW-1:0] : i_nxt[AW-1:0];
  assign rd_addr_b = j_nxt[AW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      cnt_r   <= '0;
      n_r     <= '0;
      w_r     <= '0;
      lo_r    <= '0;
      mid_r   <= '0;
      hi_r    <= '0;
      i_r     <= '0;
      j_r     <= '0;
      k_r     <= '0;
      bank_r  <= 1'b0;
      drop_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      n_r     <= n_nxt;
      w_r     <= w_nxt;
      lo_r    <= lo_nxt;
      mid_r   <= mid_nxt;
      hi_r    <= hi_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      k_r     <= k_nxt;
      bank_r  <= bank_nxt;
      drop_r  <= drop_nxt;
    end
  end

  `ASSERT_ALWAYS(a_cnt_bound, clk, rst_n, cnt_r <= CW'(DEPTH))
  `ASSERT_IMPL(a_run_ptrs, clk, rst_n, state_r == S_RUN, (i_r <= mid_r) && (j_r <= hi_r) && (k_r < hi_r))
  `ASSERT_IMPL(a_load_free, clk, rst_n, cmd.out_load, sts.out_free)

endmodule

`default_nettype wire

FILE: tb/sorted_run_checker.sv
`timescale 1ns / 1ps

module sorted_run_checker #(
  parameter int DEPTH = ms_pkg::DEPTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  input  logic                      in_tready,
  input  logic [ms_pkg::DATA_W-1:0] in_tdata,   // [31:0] value
  input  logic                      in_tlast,
  input  logic                      out_tvalid,
  input  logic                      out_tready,
  input  logic [ms_pkg::DATA_W-1:0] out_tdata,  // [31:0] sorted_value
  input  logic                      out_tlast,
  input  logic                      out_tuser,  // [0] overflow
  output int                        errors,
  output int                        pending
);

  localparam int W = ms_pkg::DATA_W;

  typedef struct packed {
    logic signed [W-1:0] value;
    logic                tail;
    logic                ovf;
  } sorted_beat_t;

  logic signed [W-1:0] held_set [DEPTH];
  int                  held_count   = 0;
  logic                held_dropped = 1'b0;
  sorted_beat_t        expected_sorted [$];
  int                  error_total  = 0;
  int                  printed      = 0;

  assign errors  = error_total;
  assign pending = expected_sorted.size();

  task automatic report_mismatch(input string msg);
    error_total++;
    if (printed < 40) begin
      $display("mismatch at %0t ns: %s", $time, msg);
      printed++;
    end
  endtask

  // ascending order; equal values are indistinguishable so any stable order works
  task automatic sort_and_queue();
    logic signed [W-1:0] key;
    int                  j;
    for (int i = 1; i < held_count; i++) begin
      key = held_set[i];
      j   = i - 1;
      while (j >= 0 && held_set[j] > key) begin
        held_set[j+1] = held_set[j];
        j--;
      end
      held_set[j+1] = key;
    end
    for (int k = 0; k < held_count; k++)
      expected_sorted.push_back('{value: held_set[k], tail: (k == held_count - 1),
                                  ovf: held_dropped});
    held_count   = 0;
    held_dropped = 1'b0;
  endtask

  task automatic take_element(input logic [W-1:0] v, input logic is_last);
    if (held_count < DEPTH) begin
      held_set[held_count] = v;
      held_count++;
    end else begin
      held_dropped = 1'b1;
    end
    if (is_last)
      sort_and_queue();
  endtask

  task automatic check_result();
    sorted_beat_t exp_beat;
    if (expected_sorted.size() == 0) begin
      report_mismatch($sformatf("result beat %h with nothing expected", out_tdata));
    end else begin
      exp_beat = expected_sorted.pop_front();
      if (out_tdata !== exp_beat.value)
        report_mismatch($sformatf("sorted_value %h, expected %h", out_tdata, exp_beat.value));
      if (out_tlast !== exp_beat.tail)
        report_mismatch($sformatf("tlast %b, expected %b on value %h", out_tlast,
                                  exp_beat.tail, exp_beat.value));
      if (out_tuser !== exp_beat.ovf)
        report_mismatch($sformatf("overflow %b, expected %b on value %h", out_tuser,
                                  exp_beat.ovf, exp_beat.value));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      held_count   = 0;
      held_dropped = 1'b0;
    end else begin
      if (out_tvalid && out_tready)
        check_result();
      if (in_tvalid && in_tready)
        take_element(in_tdata, in_tlast);
    end
  end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam int W           = ms_pkg::DATA_W;
  localparam int DEPTH       = ms_pkg::DEPTH_DEF;
  localparam int ITEM_TARGET = 320;
  localparam int HOLD_CYCLES = 400;
  localparam int IDLE_LIMIT  = 20000;

  typedef enum {RDY_ALWAYS, RDY_COIN, RDY_SPARSE} ready_mode_t;
  typedef enum {VAL_ANY, VAL_NARROW, VAL_EXTREME, VAL_MIXED} value_kind_t;

  logic         clk        = 1'b0;
  logic         rst_n      = 1'b0;
  logic         in_tvalid  = 1'b0;
  logic         in_tready;
  logic [W-1:0] in_tdata   = '0;
  logic         in_tlast   = 1'b0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [W-1:0] out_tdata;
  logic         out_tlast;
  logic         out_tuser;

  int           fail_count;
  int           pending;
  logic         hold_go    = 1'b0;
  int           burst_left = 0;
  int           items_sent = 0;
  logic [W-1:0] set_vals [$];

  merge_sorter_core #(.DEPTH(DEPTH)) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .out_tuser (out_tuser)
  );

  sorted_run_checker #(.DEPTH(DEPTH)) u_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .out_tuser (out_tuser),
    .errors    (fail_count),
    .pending   (pending)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // sender side: bursts of beats separated by random gaps
  task automatic send_beat(input logic [W-1:0] v, input logic is_last);
    int gap;
    if (burst_left == 0) begin
      if ($urandom_range(0, 7) == 0) begin
        burst_left = 40;
        gap        = 0;
      end else begin
        burst_left = $urandom_range(1, 12);
        gap        = $urandom_range(0, 5);
      end
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tdata  <= v;
    in_tlast  <= is_last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    burst_left--;
    items_sent++;
  endtask

  task automatic send_queued_set();
    for (int i = 0; i < set_vals.size(); i++)
      send_beat(set_vals[i], i == set_vals.size() - 1);
    set_vals.delete();
  endtask

  function automatic logic [W-1:0] pick_value(input value_kind_t kind);
    logic [W-1:0] corner [6];
    corner = '{32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000,
               32'hffff_ffff, 32'h0000_0001, 32'h8000_0001};
    case (kind)
      VAL_NARROW:  return $urandom_range(0, 8) - 4;
      VAL_EXTREME: return corner[$urandom_range(0, 5)];
      VAL_MIXED: begin
        if ($urandom_range(0, 2) == 0)
          return corner[$urandom_range(0, 5)];
        return $urandom;
      end
      default:     return $urandom;
    endcase
  endfunction

  // receiver side: ready pattern changes per window, plus one long hold-off
  initial begin
    ready_mode_t mode;
    int          window;
    logic        held;
    window = 0;
    held   = 1'b0;
    mode   = RDY_ALWAYS;
    forever begin
      @(posedge clk);
      if (hold_go && !held) begin
        held = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      if (window == 0) begin
        mode   = ready_mode_t'($urandom_range(0, 2));
        window = $urandom_range(16, 64);
      end
      window--;
      case (mode)
        RDY_COIN:   out_tready <= $urandom_range(0, 1);
        RDY_SPARSE: out_tready <= ($urandom_range(0, 3) == 0);
        default:    out_tready <= 1'b1;
      endcase
    end
  end

  // ends the run if nothing moves on either channel for too long
  initial begin
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
        idle = 0;
      else
        idle++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    int          set_idx;
    int          set_size;
    value_kind_t kind;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // single-element sets at both ends of the range, then short sets of corners, ties and mixed signs
    set_vals.push_back(32'h7fff_ffff);
    send_queued_set();
    set_vals.push_back(32'h8000_0000);
    send_queued_set();
    set_vals = '{32'h0000_0000, 32'hffff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h0000_0001,
                 32'h8000_0001, 32'h7fff_fffe, 32'hffff_ffff, 32'h0000_0000};
    send_queued_set();
    set_vals = '{32'h5, 32'h5, 32'h5};
    send_queued_set();
    set_vals = '{32'h3, 32'hffff_fffd, 32'h2, 32'hffff_fffe, 32'h1, 32'hffff_ffff};
    send_queued_set();
    set_vals = '{32'h7fff_ffff, 32'h8000_0000};
    send_queued_set();

    hold_go = 1'b1;
    set_idx = 0;
    while (items_sent < ITEM_TARGET) begin
      // a few full-size sets: exactly full, last beat dropped at capacity, several dropped
      case (set_idx)
        2:       set_size = DEPTH + 1;
        5:       set_size = DEPTH;
        9:       set_size = DEPTH + 4;
        default: set_size = ($urandom_range(0, 5) == 0) ? $urandom_range(13, 32)
                                                        : $urandom_range(1, 12);
      endcase
      kind = value_kind_t'($urandom_range(0, 3));
      for (int i = 0; i < set_size; i++)
        set_vals.push_back(pick_value(kind));
      send_queued_set();
      set_idx++;
    end

    @(posedge clk);
    in_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);

    if (fail_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
